FILE: rtl/positional_list_insert_delete_defines.svh
// Assertion macros used by the list datapath. Both forms expect clk and rst_n in scope.
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition c must hold in the same cycle as a.
`define PLA_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("list assertion failed");

// Condition c must hold in the cycle after a.
`define PLA_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("list assertion failed");

`else

`define PLA_ASSERT_IMPL(lbl, a, c)
`define PLA_ASSERT_NEXT(lbl, a, c)

`endif

`endif

FILE: rtl/pla_pkg.sv
package pla_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 5;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [POS_W-1:0]  position;
    logic signed [31:0] value_in;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value_out;
    logic [4:0]         count;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decide;
    logic rd_shift;
    logic wr_shift;
    logic rd_pos;
    logic commit;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ok;
    logic is_read;
    logic pos_zero;
    logic more;
    logic out_free;
  } sts_t;

  // Physical slot of a logical index; logical never exceeds CAPACITY.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] logical);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, logical};
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/positional_list_insert_delete.sv
// Sequence: a read or a refused item goes from its input beat through decide to its result
// beat; an insert or delete at position 0 also passes commit, one elsewhere also walks the
// shift loop once for each entry moved (at most 14) before commit.
// Throughput: one item at a time; the next input beat is taken only after the result is
// loaded, and the result waits in the controller while the output register is still full.
// Reset (rst_n low, synchronous): the list is emptied, head returns to slot 0, no result
// is pending and no input beat is taken; the entry store itself is not cleared.
module positional_list_insert_delete
  import pla_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // The controller sequences each item: it captures the input beat, lets the
  // datapath judge the item against the current count, walks the shift loop
  // one entry at a time, commits head and count, and finally hands the result
  // to the output register. The output register lets the finished result wait
  // for the consumer while the controller returns to accept the next beat.
  cmd_t cmd;
  sts_t sts;

  pla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the circular store, the head index, the entry count,
  // the loop index and the result register. Entries move through a registered
  // read followed by a write, so shifting never needs more than one port.
  pla_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/pla_datapath.sv
`include "positional_list_insert_delete_defines.svh"

module pla_datapath
  import pla_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  in_t  in_data,
  input  cmd_t cmd,
  input  logic out_ready,
  output sts_t sts,
  output logic out_valid,
  output out_t out_data
);

  logic [1:0]            op_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] word_r;
  logic [IDX_W-1:0]      head_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      j_r;
  logic [1:0]            status_r;
  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic                  out_valid_r;
  out_t                  out_r;

  logic [1:0]            st;
  logic                  st_ok;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      cnt_x;
  logic [CNT_W-1:0]      pos_l;
  logic                  is_insert;
  logic                  more;
  logic [IDX_W-1:0]      head_dec;
  logic [IDX_W-1:0]      head_inc;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  assign pos_x     = CMP_W'(pos_r);
  assign cnt_x     = CMP_W'(count_r);
  assign pos_l     = CNT_W'(pos_r);
  assign is_insert = (op_r == OP_INSERT);
  assign head_dec  = (head_r == '0) ? IDX_W'(CAPACITY - 1) : head_r - IDX_W'(1);
  assign head_inc  = (head_r == IDX_W'(CAPACITY - 1)) ? '0 : head_r + IDX_W'(1);

  // Status of the held item against the state before it.
  always_comb begin
    st = ST_BAD_POS;
    unique case (op_r)
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          st = ST_BAD_POS;
        end else if (count_r >= CNT_W'(CAPACITY)) begin
          st = ST_FULL;
        end else begin
          st = ST_OK;
        end
      end
      OP_DELETE, OP_READ: begin
        if (count_r == '0) begin
          st = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          st = ST_BAD_POS;
        end else begin
          st = ST_OK;
        end
      end
      default: st = ST_BAD_POS;
    endcase
  end

  assign st_ok = (st == ST_OK);

  // Insert moves entries from the tail down to the position; delete moves
  // entries after the position up toward it.
  assign more = is_insert ? (j_r > pos_l)
                          : (({1'b0, j_r} + (CNT_W + 1)'(1)) < {1'b0, count_r});

  assign sts.ok       = st_ok;
  assign sts.is_read  = (op_r == OP_READ);
  assign sts.pos_zero = (pos_r == '0);
  assign sts.more     = more;
  assign sts.out_free = !out_valid_r || out_ready;

  assign rd_en   = cmd.rd_shift || cmd.rd_pos;
  assign rd_addr = cmd.rd_pos ? slot_of(head_r, pos_l)
                 : slot_of(head_r, is_insert ? j_r - CNT_W'(1) : j_r + CNT_W'(1));
  assign wr_en   = cmd.wr_shift || (cmd.commit && is_insert);
  assign wr_addr = cmd.wr_shift ? slot_of(head_r, j_r)
                 : ((pos_r == '0) ? head_dec : slot_of(head_r, pos_l));
  assign wr_data = cmd.wr_shift ? rdata_r : word_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_data.operation;
      pos_r  <= in_data.position;
      word_r <= DATA_WIDTH'($unsigned(in_data.value_in));
    end
    if (cmd.decide) begin
      status_r <= st;
      j_r      <= is_insert ? count_r : pos_l;
    end else if (cmd.wr_shift) begin
      j_r <= is_insert ? j_r - CNT_W'(1) : j_r + CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_r.status    <= status_r;
      out_r.value_out <= (sts.is_read && status_r == ST_OK) ? 32'(rdata_r) : '0;
      out_r.count     <= 5'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        if (is_insert) begin
          count_r <= count_r + CNT_W'(1);
          if (pos_r == '0) begin
            head_r <= head_dec;
          end
        end else begin
          count_r <= count_r - CNT_W'(1);
          if (pos_r == '0) begin
            head_r <= head_inc;
          end
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PLA_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY))
  `PLA_ASSERT_NEXT(a_insert_count, cmd.commit && is_insert, count_r == $past(count_r) + CNT_W'(1))
  `PLA_ASSERT_NEXT(a_delete_count, cmd.commit && !is_insert, count_r == $past(count_r) - CNT_W'(1))
  `PLA_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !out_valid_r || out_ready)

endmodule

FILE: rtl/pla_ctrl.sv
module pla_ctrl
  import pla_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECIDE   = 3'd1;
  localparam logic [2:0] S_LOOP     = 3'd2;
  localparam logic [2:0] S_SHIFT_WR = 3'd3;
  localparam logic [2:0] S_COMMIT   = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // No beat is taken while reset is held.
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (!sts.ok) begin
          state_nxt = S_DONE;
        end else if (sts.is_read) begin
          cmd.rd_pos = 1'b1;
          state_nxt  = S_DONE;
        end else if (sts.pos_zero) begin
          state_nxt = S_COMMIT;
        end else begin
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (sts.more) begin
          cmd.rd_shift = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = S_LOOP;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: tb/sv/tb_positional_list_insert_delete.sv
module tb_positional_list_insert_delete;
  timeunit 1ns;
  timeprecision 1ps;

  import pla_pkg::*;

  // The one operation code the block does not define.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // A run is stopped when this many cycles pass without a beat on either channel.
  // The slowest item moves fourteen entries through the shift loop before its result beat, so
  // this leaves a wide margin even when long sender gaps and receiver stalls line up.
  localparam int WATCHDOG_LIMIT = 3000;
  // Cycles to wait after the last expected result, well past the longest item latency.
  localparam int TAIL_CYCLES    = 60;
  localparam int MAX_REPORTS    = 100;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  positional_list_insert_delete dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the list. It is updated at the moment an input beat is accepted, so the
  // stimulus generator always sees the list as the block will see it for the next item.
  logic signed [DATA_WIDTH-1:0] shadow_words [CAPACITY];
  logic [IDX_W-1:0]             shadow_head  = '0;
  logic [4:0]                   shadow_count = '0;

  out_t        pending_results[$];
  int unsigned items_taken    = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // Percentages that shape the traffic; changed by the test tasks between phases.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Physical slot that holds a logical position, counted from the shadow head.
  function automatic int unsigned shadow_slot(input int unsigned logical);
    return (shadow_head + logical) % CAPACITY;
  endfunction

  // Applies one operation to the shadow list and returns the result the block must give.
  // A failed operation leaves the list untouched and returns a zero word.
  function automatic out_t list_apply(input in_t item);
    out_t        res;
    int unsigned j;
    res.status    = ST_BAD_POS;
    res.value_out = '0;
    case (item.operation)
      OP_INSERT: begin
        // The position check comes before the full check.
        if (item.position > shadow_count) begin
          res.status = ST_BAD_POS;
        end else if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          if (item.position == 0) begin
            // Inserting at the front just steps the head back one slot.
            shadow_head = IDX_W'((shadow_head + CAPACITY - 1) % CAPACITY);
          end else begin
            for (j = shadow_count; j > item.position; j--) begin
              shadow_words[shadow_slot(j)] = shadow_words[shadow_slot(j - 1)];
            end
          end
          shadow_words[shadow_slot(item.position)] = item.value_in;
          shadow_count = shadow_count + 5'd1;
          res.status   = ST_OK;
        end
      end
      OP_DELETE: begin
        // An empty list is reported before any position check.
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (item.position >= shadow_count) begin
          res.status = ST_BAD_POS;
        end else begin
          if (item.position == 0) begin
            shadow_head = IDX_W'((shadow_head + 1) % CAPACITY);
          end else begin
            for (j = item.position; j + 1 < shadow_count; j++) begin
              shadow_words[shadow_slot(j)] = shadow_words[shadow_slot(j + 1)];
            end
          end
          shadow_count = shadow_count - 5'd1;
          res.status   = ST_OK;
        end
      end
      OP_READ: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (item.position >= shadow_count) begin
          res.status = ST_BAD_POS;
        end else begin
          res.value_out = shadow_words[shadow_slot(item.position)];
          res.status    = ST_OK;
        end
      end
      default: begin
        // The unused operation code is refused as a bad position and changes nothing.
        res.status = ST_BAD_POS;
      end
    endcase
    res.count = shadow_count;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // All checking happens here, on the rising edge, from values that were settled before it.
  // The result beat is handled before the input beat: with one item in flight at a time a
  // result can never belong to an item accepted at the same edge.
  always @(posedge clk) begin : check_beats
    out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected (status %0d count %0d)",
                                    out_data.status, out_data.count));
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status) begin
            report_mismatch($sformatf("status got %0d want %0d", out_data.status, want.status));
          end
          if (out_data.value_out !== want.value_out) begin
            report_mismatch($sformatf("value_out got %0d want %0d",
                                      out_data.value_out, want.value_out));
          end
          if (out_data.count !== want.count) begin
            report_mismatch($sformatf("count got %0d want %0d", out_data.count, want.count));
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(list_apply(in_data));
        items_taken++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // The receiver decides each cycle, at the falling edge, whether it takes a result beat.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offers one input beat and returns at the falling edge after it has been taken. Valid is
  // left high on return, so the next call either drops it for an idle gap or replaces the
  // payload; either way valid gets a single assignment in that time step.
  task automatic send_item(input in_t item);
    int unsigned taken_before;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data      <= item;
    taken_before = items_taken;
    do @(negedge clk); while (items_taken == taken_before);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [4:0] pos,
                         input logic signed [31:0] word);
    in_t item;
    item.operation = op;
    item.position  = pos;
    item.value_in  = word;
    send_item(item);
  endtask

  // Holds the input channel idle until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // Hand-picked beats: empty-list checks, the unused operation code, head wrap on front
  // inserts, inserts and deletes in the middle, at the end and at the front, and the
  // extreme words.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_op(OP_READ,   5'd0,  $urandom);
    send_op(OP_DELETE, 5'd0,  $urandom);
    send_op(OP_DELETE, 5'd31, $urandom);
    send_op(OP_INSERT, 5'd1,  32'sd5);
    send_op(OP_INSERT, 5'd31, -32'sd1);
    send_op(OP_UNUSED, 5'd0,  32'sd7);
    send_op(OP_INSERT, 5'd0,  32'sh7fff_ffff);
    send_op(OP_INSERT, 5'd0,  32'sh8000_0000);
    send_op(OP_INSERT, 5'd2,  -32'sd1);
    send_op(OP_INSERT, 5'd1,  32'sd0);
    send_op(OP_INSERT, 5'd2,  32'sh5555_5555);
    for (int p = 0; p <= 5; p++) begin
      send_op(OP_READ, 5'(p), $urandom);
    end
    send_op(OP_DELETE, 5'd2,  $urandom);
    send_op(OP_DELETE, 5'd0,  $urandom);
    send_op(OP_DELETE, 5'd2,  $urandom);
    send_op(OP_DELETE, 5'd5,  $urandom);
    send_op(OP_READ,   5'd0,  $urandom);
    send_op(OP_READ,   5'd1,  $urandom);
    send_op(OP_UNUSED, 5'd31, -32'sd1);
  endtask

  // Fills the list to capacity, probes the full list, then empties it again from random
  // positions. The pause in the middle lets every result drain before the probes go out.
  task automatic test_full_list();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    while (shadow_count < CAPACITY) begin
      send_op(OP_INSERT, 5'($urandom_range(shadow_count)), $urandom);
    end
    wait_drained();
    send_op(OP_INSERT, 5'd16, $urandom);
    send_op(OP_INSERT, 5'd17, $urandom);
    send_op(OP_INSERT, 5'd0,  $urandom);
    send_op(OP_READ,   5'd15, $urandom);
    send_op(OP_READ,   5'd16, $urandom);
    send_op(OP_DELETE, 5'd16, $urandom);
    while (shadow_count > 0) begin
      send_op(OP_DELETE, 5'($urandom_range(shadow_count - 1)), $urandom);
    end
    send_op(OP_DELETE, 5'd0, $urandom);
    send_op(OP_READ,   5'd0, $urandom);
  endtask

  // Mostly well-formed traffic that swings the list between empty and full, so the head
  // wraps many times and every shift length is exercised. About one beat in twelve is
  // noise: any operation code with any position, which mostly lands on the refusals.
  task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
    logic [1:0]         op;
    logic [4:0]         pos;
    logic signed [31:0] word;
    int                 roll;
    bit                 growing;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    growing        = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (shadow_count == CAPACITY) begin
        growing = 1'b0;
      end else if (shadow_count == 0) begin
        growing = 1'b1;
      end
      case ($urandom_range(7))
        0:       word = 32'sh7fff_ffff;
        1:       word = 32'sh8000_0000;
        2:       word = -32'sd1;
        3:       word = 32'sd0;
        default: word = $urandom;
      endcase
      if ($urandom_range(99) < 8) begin
        op  = 2'($urandom_range(3));
        pos = 5'($urandom_range(31));
      end else begin
        roll = $urandom_range(99);
        if (roll < 30) begin
          op = OP_READ;
        end else if (roll < (growing ? 75 : 55)) begin
          op = OP_INSERT;
        end else begin
          op = OP_DELETE;
        end
        if (op == OP_INSERT) begin
          pos = 5'($urandom_range(shadow_count));
        end else if (shadow_count == 0) begin
          pos = 5'd0;
        end else begin
          pos = 5'($urandom_range(shadow_count - 1));
        end
      end
      // Now and then the sender holds off until the block has answered everything.
      if ($urandom_range(39) == 0) begin
        wait_drained();
      end
      send_op(op, pos, word);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_full_list();
    test_random_traffic(140, 0,  0);
    test_random_traffic(140, 83, 0);
    test_random_traffic(140, 0,  83);
    test_random_traffic(140, 34, 34);

    // Let the last results come home, then watch a while longer for stray result beats.
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
